[rtl/tdp_pkg.sv]
// Package for the trial-division prime tester: defaults, constants and state type.
`default_nettype none

package tdp_pkg;

    // Default width of the number under test
    localparam int NUM_WIDTH_DEF = 16;

    // First odd trial divisor and its square
    localparam int FIRST_DIVISOR = 3;
    localparam int FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_NEXT  = 5'b01000,
        ST_DONE  = 5'b10000
    } tdp_state_t;

endpackage : tdp_pkg

`default_nettype wire

[rtl/trial_division_prime_test.sv]
// Trial-division prime tester: sequencer around one bit-serial remainder unit.
// Steps: 0, 1, 2 and even numbers go straight to DONE; otherwise CHECK, DIV and NEXT
// repeat for each odd divisor tried (at most about 2^(NUM_WIDTH/2)/2 of them) until DONE.
// Throughput: one item at a time; the single restoring divider (one quotient bit
// per cycle) sets the rate.
// A finished result waits in the output register while the next item is taken.
// Reset: aresetn, synchronous, active low; clears the sequencer and m_tvalid.
`default_nettype none

module trial_division_prime_test
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input items
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((NUM_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // [NUM_WIDTH-1:0] candidate
    // result items
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [7:0]                                m_tdata   // [0] is_prime
);

    localparam int SQ_W  = 2 * NUM_WIDTH;
    localparam int CNT_W = $clog2(NUM_WIDTH);

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    tdp_state_t               state_reg, state_next;
    logic [NUM_WIDTH-1:0]     value_reg, value_next;     // number under test
    logic [NUM_WIDTH-1:0]     div_reg, div_next;         // current odd divisor
    logic [SQ_W-1:0]          sq_reg, sq_next;           // div_reg squared, kept by increments
    logic [NUM_WIDTH-1:0]     rem_reg, rem_next;         // partial remainder
    logic [NUM_WIDTH-1:0]     shift_reg, shift_next;     // dividend bits still to bring down
    logic [CNT_W-1:0]         cnt_reg, cnt_next;         // divider step counter
    logic                     prime_reg, prime_next;     // verdict for DONE
    logic                     m_tvalid_reg, m_tvalid_next;
    logic                     m_prime_reg, m_prime_next;

    // Restoring divider step
    logic [NUM_WIDTH:0]       trial;
    logic                     fits;
    logic [NUM_WIDTH-1:0]     rem_step;
    logic [NUM_WIDTH-1:0]     in_value;
    logic                     out_free;

    assign in_value = s_tdata[NUM_WIDTH-1:0];
    assign trial    = {rem_reg, shift_reg[NUM_WIDTH-1]};
    assign fits     = trial >= {1'b0, div_reg};
    assign rem_step = fits ? NUM_WIDTH'(trial - {1'b0, div_reg}) : trial[NUM_WIDTH-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_prime_reg};

    always_comb begin
        state_next    = state_reg;
        value_next    = value_reg;
        div_next      = div_reg;
        sq_next       = sq_reg;
        rem_next      = rem_reg;
        shift_next    = shift_reg;
        cnt_next      = cnt_reg;
        prime_next    = prime_reg;
        m_tvalid_next = m_tvalid_reg;
        m_prime_next  = m_prime_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    value_next = in_value;
                    div_next   = NUM_WIDTH'(FIRST_DIVISOR);
                    sq_next    = SQ_W'(FIRST_SQUARE);
                    if (in_value == NUM_WIDTH'(2)) begin
                        prime_next = 1'b1;
                        state_next = ST_DONE;
                    end else if (in_value < NUM_WIDTH'(2) || !in_value[0]) begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // divisor squared beyond the number: no factor left to find
                if (sq_reg > {{NUM_WIDTH{1'b0}}, value_reg}) begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rem_next   = '0;
                    shift_next = value_reg;
                    cnt_next   = CNT_W'(NUM_WIDTH - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next   = rem_step;
                shift_next = {shift_reg[NUM_WIDTH-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (rem_step == '0) begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT: begin
                // (d+2)^2 = d^2 + 4d + 4
                div_next   = div_reg + NUM_WIDTH'(2);
                sq_next    = sq_reg + {{(SQ_W - NUM_WIDTH - 2){1'b0}}, div_reg, 2'b00}
                             + SQ_W'(4);
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_prime_next  = prime_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        div_reg     <= div_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        cnt_reg     <= cnt_next;
        prime_reg   <= prime_next;
        m_prime_reg <= m_prime_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // partial remainder always below the divisor while dividing
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");

    // trial divisors stay odd
    a_div_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK || state_reg == ST_DIV || state_reg == ST_NEXT)
        |-> div_reg[0])
        else $error("even trial divisor");

    // incremental square tracks the divisor
    a_sq_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (sq_reg == SQ_W'(div_reg) * SQ_W'(div_reg)))
        else $error("divisor square out of step");

    // a new result appears only out of the DONE state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside DONE");

    // the divider's last step leads only to DONE or NEXT
    a_divider_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == '0) |=> (state_reg == ST_DONE || state_reg == ST_NEXT))
        else $error("divider left to wrong state");

endmodule : trial_division_prime_test

`default_nettype wire
